// ===== hdl/pstg_pkg.sv =====
// Shared types and constants for the polyphonic square tone generator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package pstg_pkg;

    localparam int unsigned CLOCK_HZ = 16000000;

    localparam int BASE_W  = 16;
    localparam int KEY_W   = 8;
    localparam int MULT_W  = 5;
    localparam int DUTY_W  = 9;
    localparam int PHASE_W = 32;
    localparam int AGE_W   = 32;

    localparam logic [MULT_W-1:0] MULT_MIN = MULT_W'(1);
    localparam logic [MULT_W-1:0] MULT_MAX = MULT_W'(16);

    // increment divider: four quotient bits per cycle
    localparam int PROD_W     = BASE_W + MULT_W;
    localparam int DIGIT_W    = 4;
    localparam int INC_STEPS  = (PROD_W + PHASE_W + DIGIT_W - 1) / DIGIT_W;
    localparam int NUM_W      = INC_STEPS * DIGIT_W;
    localparam int STEP_CNT_W = $clog2(INC_STEPS);

    typedef enum logic [1:0] {
        ACT_NOTE_ON  = 2'd0,
        ACT_NOTE_OFF = 2'd1,
        ACT_ALL_OFF  = 2'd2,
        ACT_TICK     = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ON_APPLY,
        ST_OFF_APPLY,
        ST_TICK_VOICE,
        ST_TICK_WAIT,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/pstg_inc_unit.sv =====
// Phase increment unit: (base * mult * 2^32) / sample rate, low 32 bits.
// Radix-16 restoring divider, one digit per cycle. Uses pstg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pstg_inc_unit
    import pstg_pkg::*;
#(
    parameter int PWM_TOP = 511
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [BASE_W-1:0]  base_freq,
    input  wire logic [MULT_W-1:0]  mult,
    output logic                    done,
    output logic [PHASE_W-1:0]      inc
);

    localparam int unsigned RATE = CLOCK_HZ / (PWM_TOP + 1);
    localparam int RW = $clog2(RATE);
    localparam logic [RW:0] RATE_C = (RW + 1)'(RATE);
    localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(INC_STEPS - 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic [RW-1:0]         rem_reg, rem_next;
    logic [PHASE_W-1:0]    quo_reg, quo_next;
    logic [NUM_W-1:0]      num_reg, num_next;
    logic [PROD_W-1:0]     prod;
    logic [RW-1:0]         rem_step;
    logic [PHASE_W-1:0]    quo_step;

    assign prod = PROD_W'(base_freq) * PROD_W'(mult);

    always_comb
    begin : digit_step
        logic [RW:0] t;
        rem_step = rem_reg;
        quo_step = quo_reg;
        for (int j = 0; j < DIGIT_W; j++)
        begin
            t = {rem_step, num_reg[NUM_W-1-j]};
            if (t >= RATE_C)
            begin
                t        = t - RATE_C;
                quo_step = {quo_step[PHASE_W-2:0], 1'b1};
            end
            else
            begin
                quo_step = {quo_step[PHASE_W-2:0], 1'b0};
            end
            rem_step = t[RW-1:0];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        num_next  = num_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = '0;
            num_next  = NUM_W'({prod, {PHASE_W{1'b0}}});
        end
        else if (busy_reg)
        begin
            rem_next = rem_step;
            quo_next = quo_step;
            num_next = num_reg << DIGIT_W;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        num_reg <= num_next;
    end

    assign done = done_reg;
    assign inc  = quo_reg;

endmodule

`default_nettype wire

// ===== hdl/pstg_out_reg.sv =====
// Output word register with valid/stall handshake.
// Loads a new duty word whenever the held one is taken or absent. Uses pstg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pstg_out_reg
    import pstg_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire logic [DUTY_W-1:0] din,
    output logic                   room,
    output logic                   valid,
    input  wire logic              stall,
    output logic [DUTY_W-1:0]      dout
);

    logic              valid_reg, valid_next;
    logic [DUTY_W-1:0] data_reg, data_next;

    assign room = !valid_reg || !stall;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (room)
        begin
            valid_next = load;
            if (load)
            begin
                data_next = din;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign dout  = data_reg;

endmodule

`default_nettype wire

// ===== hdl/polyphonic_square_tone_generator.sv =====
// Polyphonic square tone generator: top level, voice store and sequencer.
// Uses pstg_pkg, pstg_inc_unit and pstg_out_reg.
//
// Input channel (in_valid/in_stall): action, key, base_freq. One word is
// taken at a time; in_stall stays high until the sequencer is idle again.
// Note-on and note-off scan the voices one per cycle (a note-on with zero
// base_freq is dropped). All-off clears every voice and emits the midpoint duty.
// A sample tick visits the voices one per cycle, but waits at each active
// voice while the phase increment divider (4 quotient bits per cycle) runs,
// then adds the increment to the voice's phase.
// Output channel (out_valid/out_stall): duty, held in an output register.
// While out_stall is high the word is held; a finished tick or all-off waits
// in ST_EMIT with in_stall high, so no input word is taken until it emits.
// freq_multiplier is written when freq_multiplier_we is high, clamped to
// 1..16, and applies to every phase increment started after the write.
// Reset (rst_n low, asynchronous) silences all voices, clears the age
// counter, sets the multiplier to 1 and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module polyphonic_square_tone_generator
    import pstg_pkg::*;
#(
    parameter int VOICES  = 4,
    parameter int PWM_TOP = 511
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        action,
    input  wire logic [KEY_W-1:0]  key,
    input  wire logic [BASE_W-1:0] base_freq,
    input  wire logic              freq_multiplier_we,
    input  wire logic [MULT_W-1:0] freq_multiplier,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [DUTY_W-1:0]      duty
);

    localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int ACC_W  = $clog2(PWM_TOP + 1) + 2;
    localparam int MID    = PWM_TOP / 2;
    localparam int AMP    = MID / VOICES;
    localparam logic signed [ACC_W-1:0] MID_C = ACC_W'(MID);
    localparam logic signed [ACC_W-1:0] AMP_C = ACC_W'(AMP);
    localparam logic signed [ACC_W-1:0] TOP_C = ACC_W'(PWM_TOP);
    localparam logic [VIDX_W-1:0] LAST_V = VIDX_W'(VOICES - 1);

    state_t                    state_reg, state_next;
    logic [VIDX_W-1:0]         vidx_reg, vidx_next;
    action_t                   act_reg, act_next;
    logic [KEY_W-1:0]          key_reg, key_next;
    logic [BASE_W-1:0]         base_reg, base_next;
    logic [VOICES-1:0]         active_reg, active_next;
    logic [AGE_W-1:0]          age_cnt_reg, age_cnt_next;
    logic [MULT_W-1:0]         mult_reg, mult_next;
    logic                      match_found_reg, match_found_next;
    logic [VIDX_W-1:0]         match_idx_reg, match_idx_next;
    logic                      free_found_reg, free_found_next;
    logic [VIDX_W-1:0]         free_idx_reg, free_idx_next;
    logic [VIDX_W-1:0]         best_idx_reg, best_idx_next;
    logic [AGE_W-1:0]          best_age_reg, best_age_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;

    logic [KEY_W-1:0]          voice_key_reg   [VOICES];
    logic [BASE_W-1:0]         voice_base_reg  [VOICES];
    logic [PHASE_W-1:0]        voice_phase_reg [VOICES];
    logic [AGE_W-1:0]          voice_age_reg   [VOICES];

    logic                      accept;
    logic                      note_we;
    logic [VIDX_W-1:0]         note_idx;
    logic                      phase_we;
    logic [PHASE_W-1:0]        phase_sum;
    logic                      inc_start;
    logic                      inc_done;
    logic [PHASE_W-1:0]        inc;
    logic                      out_room;
    logic                      out_load;
    logic signed [ACC_W-1:0]   clamped;
    logic [DUTY_W-1:0]         duty_c;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign phase_sum = voice_phase_reg[vidx_reg] + inc;

    always_comb
    begin
        if (acc_reg < 0)
        begin
            clamped = '0;
        end
        else if (acc_reg > TOP_C)
        begin
            clamped = TOP_C;
        end
        else
        begin
            clamped = acc_reg;
        end
        duty_c = DUTY_W'($unsigned(clamped));
    end

    always_comb
    begin
        if (!freq_multiplier_we)
        begin
            mult_next = mult_reg;
        end
        else if (freq_multiplier < MULT_MIN)
        begin
            mult_next = MULT_MIN;
        end
        else if (freq_multiplier > MULT_MAX)
        begin
            mult_next = MULT_MAX;
        end
        else
        begin
            mult_next = freq_multiplier;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        vidx_next        = vidx_reg;
        act_next         = act_reg;
        key_next         = key_reg;
        base_next        = base_reg;
        active_next      = active_reg;
        age_cnt_next     = age_cnt_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        best_idx_next    = best_idx_reg;
        best_age_next    = best_age_reg;
        acc_next         = acc_reg;
        note_we          = 1'b0;
        note_idx         = best_idx_reg;
        phase_we         = 1'b0;
        inc_start        = 1'b0;
        out_load         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    act_next         = action_t'(action);
                    key_next         = key;
                    base_next        = base_freq;
                    vidx_next        = '0;
                    match_found_next = 1'b0;
                    free_found_next  = 1'b0;
                    case (action_t'(action))
                        ACT_NOTE_ON:
                        begin
                            if (base_freq != '0)
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        ACT_NOTE_OFF:
                        begin
                            state_next = ST_SCAN;
                        end
                        ACT_ALL_OFF:
                        begin
                            active_next = '0;
                            acc_next    = MID_C;
                            state_next  = ST_EMIT;
                        end
                        ACT_TICK:
                        begin
                            acc_next   = MID_C;
                            state_next = ST_TICK_VOICE;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (active_reg[vidx_reg] && voice_key_reg[vidx_reg] == key_reg
                    && !match_found_reg)
                begin
                    match_found_next = 1'b1;
                    match_idx_next   = vidx_reg;
                end
                if (!active_reg[vidx_reg] && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = vidx_reg;
                end
                // strict compare: on equal ages the lower voice is kept
                if (vidx_reg == '0 || voice_age_reg[vidx_reg] < best_age_reg)
                begin
                    best_idx_next = vidx_reg;
                    best_age_next = voice_age_reg[vidx_reg];
                end
                if (vidx_reg == LAST_V)
                begin
                    state_next = (act_reg == ACT_NOTE_ON) ? ST_ON_APPLY : ST_OFF_APPLY;
                end
                else
                begin
                    vidx_next = vidx_reg + 1'b1;
                end
            end

            ST_ON_APPLY:
            begin
                note_we = 1'b1;
                if (match_found_reg)
                begin
                    note_idx = match_idx_reg;
                end
                else if (free_found_reg)
                begin
                    note_idx = free_idx_reg;
                end
                else
                begin
                    note_idx = best_idx_reg;
                end
                active_next[note_idx] = 1'b1;
                age_cnt_next          = age_cnt_reg + 1'b1;
                state_next            = ST_IDLE;
            end

            ST_OFF_APPLY:
            begin
                if (match_found_reg)
                begin
                    active_next[match_idx_reg] = 1'b0;
                end
                state_next = ST_IDLE;
            end

            ST_TICK_VOICE:
            begin
                if (active_reg[vidx_reg])
                begin
                    inc_start  = 1'b1;
                    state_next = ST_TICK_WAIT;
                end
                else if (vidx_reg == LAST_V)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    vidx_next = vidx_reg + 1'b1;
                end
            end

            ST_TICK_WAIT:
            begin
                if (inc_done)
                begin
                    phase_we = 1'b1;
                    acc_next = phase_sum[PHASE_W-1] ? (acc_reg + AMP_C) : (acc_reg - AMP_C);
                    if (vidx_reg == LAST_V)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        vidx_next  = vidx_reg + 1'b1;
                        state_next = ST_TICK_VOICE;
                    end
                end
            end

            ST_EMIT:
            begin
                if (out_room)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            vidx_reg    <= '0;
            active_reg  <= '0;
            age_cnt_reg <= '0;
            mult_reg    <= MULT_MIN;
        end
        else
        begin
            state_reg   <= state_next;
            vidx_reg    <= vidx_next;
            active_reg  <= active_next;
            age_cnt_reg <= age_cnt_next;
            mult_reg    <= mult_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg         <= act_next;
        key_reg         <= key_next;
        base_reg        <= base_next;
        match_found_reg <= match_found_next;
        match_idx_reg   <= match_idx_next;
        free_found_reg  <= free_found_next;
        free_idx_reg    <= free_idx_next;
        best_idx_reg    <= best_idx_next;
        best_age_reg    <= best_age_next;
        acc_reg         <= acc_next;
    end

    // voice store; entries only matter while the voice is active
    always_ff @(posedge clk)
    begin
        if (note_we)
        begin
            voice_key_reg[note_idx]   <= key_reg;
            voice_base_reg[note_idx]  <= base_reg;
            voice_phase_reg[note_idx] <= '0;
            voice_age_reg[note_idx]   <= age_cnt_reg;
        end
        else if (phase_we)
        begin
            voice_phase_reg[vidx_reg] <= phase_sum;
        end
    end

    pstg_inc_unit #(
        .PWM_TOP   (PWM_TOP)
    ) u_inc (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (inc_start),
        .base_freq (voice_base_reg[vidx_reg]),
        .mult      (mult_reg),
        .done      (inc_done),
        .inc       (inc)
    );

    pstg_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .din       (duty_c),
        .room      (out_room),
        .valid     (out_valid),
        .stall     (out_stall),
        .dout      (duty)
    );

endmodule

`default_nettype wire
